[design/ptds_pkg.sv]
`default_nettype none
package ptds_pkg;

  // Field widths fixed by the interface
  localparam int TIME_W    = 48;
  localparam int INTV_W    = 32;
  localparam int SKIP_W    = 32;
  localparam int IDX_W     = 2;
  localparam int ACT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Parameter defaults
  localparam int TASK_SLOTS_DEF = 4;
  localparam int TIME_BITS_DEF  = 48;

  // Register indexes
  localparam int REG_ACTIVE = 0;
  localparam int REG_INTV0  = 1;
  localparam int INTV_REGS  = 4;

  // Interval held after reset
  localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(1000);

  // Operation codes
  localparam logic FUNC_SELECT   = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  // Saturating add of two time-wide values against a limit (a never above lim)
  function automatic logic [TIME_W-1:0] sat_add_t(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b,
                                                  input logic [TIME_W-1:0] lim);
    logic [TIME_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, lim}) ? lim : s[TIME_W-1:0];
    end
  endfunction

  // Saturating add of two skip counts
  function automatic logic [SKIP_W-1:0] sat_add_s(input logic [SKIP_W-1:0] a,
                                                  input logic [SKIP_W-1:0] b);
    logic [SKIP_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[SKIP_W] ? {SKIP_W{1'b1}} : s[SKIP_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[design/periodic_task_due_scheduler_core.sv]
`default_nettype none
// Periodic task due scheduler: earliest due time first over TASK_SLOTS slots.
// Input channel: an item is taken at a rising edge with start high and busy low.
//   func selects: select due task (current_time) or report completion
//   (task_number, start_time, finish_time, job_failed).
// Result channel: done is high for exactly one cycle with the result fields;
//   the receiver cannot stall, so the block never waits on it. Totals outputs
//   always show the running sums and are valid with done.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
//   the active slot count, indexes 1..4 the slot intervals. Write only while idle.
// Sequencing: a select scans one slot a cycle in S_SCAN, then reports in S_SRES
//   (straight to S_SRES when no slot is active). A completion runs S_CLOAD,
//   S_CDIFF, S_CADD, S_WB when the due time already lies past the finish time,
//   adding S_DGO, S_DIV (48-step restoring divider) and S_FIX when missed
//   intervals must be counted. A completion for a slot beyond the table
//   answers in the next cycle. One item is in flight at a time; busy stays high meanwhile.
// Reset (rst, synchronous): all due times and skip counts zero, intervals
//   1000, no slot active, totals zero.
module periodic_task_due_scheduler_core #(
  parameter int TASK_SLOTS = ptds_pkg::TASK_SLOTS_DEF,
  parameter int TIME_BITS  = ptds_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              func,
  input  wire logic [ptds_pkg::TIME_W-1:0]       current_time,
  input  wire logic [ptds_pkg::IDX_W-1:0]        task_number,
  input  wire logic [ptds_pkg::TIME_W-1:0]       start_time,
  input  wire logic [ptds_pkg::TIME_W-1:0]       finish_time,
  input  wire logic                              job_failed,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ptds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ptds_pkg::CFG_DAT_W-1:0]    cfg_data,
  output logic                                   done,
  output logic                                   found,
  output logic      [ptds_pkg::IDX_W-1:0]        task_index,
  output logic      [ptds_pkg::TIME_W-1:0]       due_time,
  output logic      [ptds_pkg::SKIP_W-1:0]       task_skipped,
  output logic      [ptds_pkg::TIME_W-1:0]       executed_total,
  output logic      [ptds_pkg::TIME_W-1:0]       error_total,
  output logic      [ptds_pkg::TIME_W-1:0]       lateness_total,
  output logic      [ptds_pkg::TIME_W-1:0]       duration_total,
  output logic      [ptds_pkg::TIME_W-1:0]       skipped_total
);

  localparam int TW     = ptds_pkg::TIME_W;
  localparam int SW     = ptds_pkg::SKIP_W;
  localparam int IW     = ptds_pkg::INTV_W;
  localparam int AW     = ptds_pkg::ACT_W;
  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam logic [TW-1:0] TIME_LIM = (TIME_BITS >= TW) ? {TW{1'b1}} :
                                       TW'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [TW-1:0] TOT_LIM  = {TW{1'b1}};
  localparam logic [SW-1:0] SKIP_LIM = {SW{1'b1}};

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SRES  = 4'd2;
  localparam logic [3:0] S_CLOAD = 4'd3;
  localparam logic [3:0] S_CDIFF = 4'd4;
  localparam logic [3:0] S_CADD  = 4'd5;
  localparam logic [3:0] S_DGO   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIX   = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;

  logic [3:0] state;

  // Latched item
  logic              in_func;
  logic              in_failed;
  logic [1:0]        in_slot;
  logic [TW-1:0]     in_now;
  logic [TW-1:0]     in_start;
  logic [TW-1:0]     in_finish;

  // Configuration and slot state
  logic [AW-1:0]     active;
  logic [IW-1:0]     intv     [TASK_SLOTS];
  logic [TW-1:0]     due_tab  [TASK_SLOTS];
  logic [SW-1:0]     skip_tab [TASK_SLOTS];

  // Totals
  logic [TW-1:0]     executed_count;
  logic [TW-1:0]     error_count;
  logic [TW-1:0]     lateness_sum;
  logic [TW-1:0]     duration_sum;
  logic [TW-1:0]     skipped_sum;

  // Scan registers
  logic [SLOT_W-1:0] ptr;
  logic              have_due;
  logic              have_any;
  logic [TW-1:0]     best_due;
  logic [SLOT_W-1:0] best_idx;
  logic [SW-1:0]     best_skip;
  logic [TW-1:0]     min_due;
  logic [SLOT_W-1:0] min_idx;
  logic [SW-1:0]     min_skip;

  // Completion registers
  logic [TW-1:0]     old_due;
  logic [TW-1:0]     iv;
  logic [SW-1:0]     skip_prev;
  logic [TW-1:0]     dur_diff;
  logic [TW-1:0]     late_diff;
  logic [TW-1:0]     due_new;
  logic [TW-1:0]     span;
  logic [TW-1:0]     base;
  logic [SW-1:0]     k_sat;
  logic [SW-1:0]     new_skip;

  // Combinational helpers
  logic [AW-1:0]     n_lim;
  logic              accept;
  logic              last_slot;
  logic [TW-1:0]     rd_due;
  logic [SW-1:0]     rd_skip;
  logic [IW-1:0]     rd_intv;
  logic              d_le;
  logic              upd_due;
  logic              upd_min;
  logic              div_done;
  logic [TW-1:0]     div_q;
  logic [IW-1:0]     div_r;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign executed_total = executed_count;
  assign error_total    = error_count;
  assign lateness_total = lateness_sum;
  assign duration_total = duration_sum;
  assign skipped_total  = skipped_sum;

  // Clamp the active count to the table
  assign n_lim = (int'(active) > TASK_SLOTS) ? AW'(TASK_SLOTS) : active;

  // Single read port on the slot state, addressed by ptr
  assign rd_due  = due_tab[ptr];
  assign rd_skip = skip_tab[ptr];
  assign rd_intv = intv[ptr];

  // Scan compare
  assign last_slot = (int'(ptr) + 1 >= int'(n_lim)) || (int'(ptr) == TASK_SLOTS - 1);
  assign d_le      = (rd_due <= in_now);
  assign upd_due   = d_le && (!have_due || (rd_due < best_due));
  assign upd_min   = !have_any || (rd_due < min_due);

  // Shared divider for skipped intervals
  ptds_divider #(
    .DVD_W (TW),
    .DIV_W (IW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (state == S_DGO),
    .dividend  (span),
    .divisor   (iv[IW-1:0]),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        intv[i] <= ptds_pkg::INTV_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (int'(cfg_index) == ptds_pkg::REG_ACTIVE) begin
        active <= cfg_data[AW-1:0];
      end
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (i < ptds_pkg::INTV_REGS && int'(cfg_index) == ptds_pkg::REG_INTV0 + i) begin
          intv[i] <= cfg_data[IW-1:0];
        end
      end
    end
  end

  // Sequencer, slot state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      ptr            <= '0;
      have_due       <= 1'b0;
      have_any       <= 1'b0;
      executed_count <= '0;
      error_count    <= '0;
      lateness_sum   <= '0;
      duration_sum   <= '0;
      skipped_sum    <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        due_tab[i]  <= '0;
        skip_tab[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == ptds_pkg::FUNC_SELECT) begin
              ptr      <= '0;
              have_due <= 1'b0;
              have_any <= 1'b0;
              state    <= (n_lim == '0) ? S_SRES : S_SCAN;
            end else if (int'(task_number) < TASK_SLOTS) begin
              ptr   <= SLOT_W'(task_number);
              state <= S_CLOAD;
            end else begin
              // Slot beyond the table: answer at once, no state change
              found        <= 1'b0;
              task_index   <= task_number;
              due_time     <= '0;
              task_skipped <= '0;
              done         <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (upd_due) begin
            have_due  <= 1'b1;
            best_due  <= rd_due;
            best_idx  <= ptr;
            best_skip <= rd_skip;
          end
          if (upd_min) begin
            have_any <= 1'b1;
            min_due  <= rd_due;
            min_idx  <= ptr;
            min_skip <= rd_skip;
          end
          if (last_slot) begin
            state <= S_SRES;
          end else begin
            ptr <= ptr + SLOT_W'(1);
          end
        end
        S_SRES: begin
          if (have_due) begin
            found        <= 1'b1;
            task_index   <= ptds_pkg::IDX_W'(best_idx);
            due_time     <= best_due;
            task_skipped <= best_skip;
          end else if (have_any) begin
            found        <= 1'b0;
            task_index   <= ptds_pkg::IDX_W'(min_idx);
            due_time     <= min_due;
            task_skipped <= min_skip;
          end else begin
            found        <= 1'b0;
            task_index   <= '0;
            due_time     <= {TW{1'b1}};
            task_skipped <= '0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CLOAD: begin
          old_due   <= rd_due;
          skip_prev <= rd_skip;
          iv        <= (rd_intv == '0) ? TW'(1) : TW'(rd_intv);
          dur_diff  <= (in_finish > in_start) ? (in_finish - in_start) : '0;
          state     <= S_CDIFF;
        end
        S_CDIFF: begin
          late_diff <= (in_start > old_due) ? (in_start - old_due) : '0;
          due_new   <= ptds_pkg::sat_add_t(old_due, iv, TIME_LIM);
          state     <= S_CADD;
        end
        S_CADD: begin
          executed_count <= ptds_pkg::sat_add_t(executed_count, TW'(1), TOT_LIM);
          if (in_failed) begin
            error_count <= ptds_pkg::sat_add_t(error_count, TW'(1), TOT_LIM);
          end
          lateness_sum <= ptds_pkg::sat_add_t(lateness_sum, late_diff, TOT_LIM);
          duration_sum <= ptds_pkg::sat_add_t(duration_sum, dur_diff, TOT_LIM);
          if (due_new <= in_finish) begin
            span  <= in_finish - due_new;
            state <= S_DGO;
          end else begin
            new_skip <= skip_prev;
            state    <= S_WB;
          end
        end
        S_DGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            k_sat <= (div_q >= TW'(SKIP_LIM)) ? SKIP_LIM : (div_q[SW-1:0] + SW'(1));
            base  <= in_finish - TW'(div_r);
            state <= S_FIX;
          end
        end
        S_FIX: begin
          new_skip <= ptds_pkg::sat_add_s(skip_prev, k_sat);
          due_new  <= ptds_pkg::sat_add_t(base, iv, TIME_LIM);
          state    <= S_WB;
        end
        S_WB: begin
          due_tab[ptr]  <= due_new;
          skip_tab[ptr] <= new_skip;
          skipped_sum   <= ptds_pkg::sat_add_t(skipped_sum, TW'(new_skip - skip_prev),
                                               TOT_LIM);
          found         <= 1'b1;
          task_index    <= in_slot;
          due_time      <= due_new;
          task_skipped  <= new_skip;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      in_func   <= func;
      in_failed <= job_failed;
      in_slot   <= task_number;
      in_now    <= current_time & TIME_LIM;
      in_start  <= start_time & TIME_LIM;
      in_finish <= finish_time & TIME_LIM;
    end
  end

`ifndef SYNTHESIS
  a_select_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && func == ptds_pkg::FUNC_SELECT) |=> busy)
    else $error("select beat accepted but sequencer stayed idle");

  a_writeback_reports: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |=> (done && found && task_index == $past(in_slot)))
    else $error("completion write-back gave no matching result");

  a_errors_within_runs: assert property (@(posedge clk) disable iff (rst)
    (error_count <= executed_count) && !(in_func == ptds_pkg::FUNC_SELECT && state == S_CLOAD))
    else $error("error total above run total or select in completion path");
`endif

endmodule
`default_nettype wire

[design/ptds_divider.sv]
`default_nettype none
module ptds_divider #(
  parameter int DVD_W = ptds_pkg::TIME_W,
  parameter int DIV_W = ptds_pkg::INTV_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient,
  output logic      [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] div;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;

  // One restoring step: shift in the next dividend bit and trial-subtract
  assign rem_sh = {remainder, quotient[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, div};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNT_W'(DVD_W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in, keep the partial remainder
  always_ff @(posedge clk) begin
    if (go) begin
      div       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (run) begin
      remainder <= diff[DIV_W] ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
      quotient  <= {quotient[DVD_W-2:0], !diff[DIV_W]};
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < div))
    else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
  import ptds_pkg::*;

  localparam int SLOTS = TASK_SLOTS_DEF;
  localparam bit [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;
  localparam bit [63:0] SKIP_MAX = 64'hFFFF_FFFF;
  localparam int REG_SPARE_FIRST = REG_INTV0 + INTV_REGS;
  localparam int REG_LAST = (1 << CFG_IDX_W) - 1;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now;
    logic [IDX_W-1:0]  slot;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_finish;
    logic              failed;
  } job_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  slot;
    logic [TIME_W-1:0] due;
    logic [SKIP_W-1:0] skipped;
    logic [TIME_W-1:0] runs;
    logic [TIME_W-1:0] failures;
    logic [TIME_W-1:0] lateness;
    logic [TIME_W-1:0] duration;
    logic [TIME_W-1:0] skips;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 func = FUNC_SELECT;
  logic [TIME_W-1:0]    current_time = '0;
  logic [IDX_W-1:0]     task_number = '0;
  logic [TIME_W-1:0]    start_time = '0;
  logic [TIME_W-1:0]    finish_time = '0;
  logic                 job_failed = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 done;
  logic                 found;
  logic [IDX_W-1:0]     task_index;
  logic [TIME_W-1:0]    due_time;
  logic [SKIP_W-1:0]    task_skipped;
  logic [TIME_W-1:0]    executed_total;
  logic [TIME_W-1:0]    error_total;
  logic [TIME_W-1:0]    lateness_total;
  logic [TIME_W-1:0]    duration_total;
  logic [TIME_W-1:0]    skipped_total;

  periodic_task_due_scheduler_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .current_time(current_time), .task_number(task_number),
    .start_time(start_time), .finish_time(finish_time), .job_failed(job_failed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .found(found), .task_index(task_index),
    .due_time(due_time), .task_skipped(task_skipped),
    .executed_total(executed_total), .error_total(error_total),
    .lateness_total(lateness_total), .duration_total(duration_total),
    .skipped_total(skipped_total)
  );

  always #6 clk = ~clk;

  // Scheduler mirror: configuration, per-slot state and running totals
  bit [2:0]  model_active;
  bit [63:0] model_intv [SLOTS];
  bit [63:0] model_due  [SLOTS];
  bit [63:0] model_skip [SLOTS];
  bit [63:0] run_count, fail_count, late_sum, dur_sum, skip_sum;

  outcome_t pending_outcomes [$];
  int mismatches, outcomes_checked;
  int selects_sent, selects_found, completions_sent, catch_ups;
  bit gaps_on = 1'b1;

  function automatic bit [63:0] add_clamped(input bit [63:0] a, input bit [63:0] b,
                                            input bit [63:0] lim);
    return (b > lim - a) ? lim : a + b;
  endfunction

  function automatic bit [63:0] rand_time();
    return {$urandom, $urandom} & TIME_MAX;
  endfunction

  function automatic int live_slots();
    return (model_active > SLOTS) ? SLOTS : model_active;
  endfunction

  // Advance the mirror by one item and return the result it must produce
  function automatic outcome_t schedule_step(input job_t job);
    outcome_t  res;
    bit        hit, any;
    int        hit_slot, min_slot, s;
    bit [63:0] iv, prev_due, prev_skip, nxt, span, k, rem;
    res = '0;
    if (job.func == FUNC_SELECT) begin
      hit = 1'b0;
      any = 1'b0;
      hit_slot = 0;
      min_slot = 0;
      for (int i = 0; i < live_slots(); i++) begin
        if (model_due[i] <= job.now && (!hit || model_due[i] < model_due[hit_slot])) begin
          hit = 1'b1;
          hit_slot = i;
        end
        if (!any || model_due[i] < model_due[min_slot]) begin
          any = 1'b1;
          min_slot = i;
        end
      end
      if (hit) begin
        res.found = 1'b1;
        res.slot = hit_slot;
        res.due = model_due[hit_slot];
        res.skipped = model_skip[hit_slot];
      end else if (any) begin
        res.slot = min_slot;
        res.due = model_due[min_slot];
        res.skipped = model_skip[min_slot];
      end else begin
        res.due = '1;
      end
    end else begin
      s = job.slot;
      iv = (model_intv[s] == 0) ? 64'd1 : model_intv[s];
      prev_due = model_due[s];
      prev_skip = model_skip[s];
      nxt = add_clamped(prev_due, iv, TIME_MAX);
      run_count = add_clamped(run_count, 1, TIME_MAX);
      if (job.failed) fail_count = add_clamped(fail_count, 1, TIME_MAX);
      late_sum = add_clamped(late_sum, (job.t_start > prev_due) ? job.t_start - prev_due : 0,
                             TIME_MAX);
      dur_sum = add_clamped(dur_sum,
                            (job.t_finish > job.t_start) ? job.t_finish - job.t_start : 0,
                            TIME_MAX);
      // Skip whole missed intervals so the next due time lies past the finish
      if (nxt <= job.t_finish) begin
        span = job.t_finish - nxt;
        k = span / iv + 1;
        rem = span % iv;
        nxt = add_clamped(job.t_finish - rem, iv, TIME_MAX);
        model_skip[s] = add_clamped(prev_skip, (k > SKIP_MAX) ? SKIP_MAX : k, SKIP_MAX);
        catch_ups++;
      end
      model_due[s] = nxt;
      skip_sum = add_clamped(skip_sum, model_skip[s] - prev_skip, TIME_MAX);
      res.found = 1'b1;
      res.slot = s;
      res.due = nxt;
      res.skipped = model_skip[s];
    end
    res.runs = run_count;
    res.failures = fail_count;
    res.lateness = late_sum;
    res.duration = dur_sum;
    res.skips = skip_sum;
    return res;
  endfunction

  function automatic bit [63:0] earliest_due();
    bit [63:0] m;
    m = TIME_MAX;
    for (int i = 0; i < live_slots(); i++)
      if (model_due[i] < m) m = model_due[i];
    return (live_slots() == 0) ? 64'($urandom_range(0, 5000)) : m;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic bit [31:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return '1;
      3: return $urandom;
      4, 5, 6: return $urandom_range(1, 50);
      default: return $urandom_range(50, 5000);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input bit [63:0] got,
                                 input bit [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input bit [63:0] got, input bit [63:0] want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", due_time, 0);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("found", found, want.found);
        check_field("task_index", task_index, want.slot);
        check_field("due_time", due_time, want.due);
        check_field("task_skipped", task_skipped, want.skipped);
        check_field("executed_total", executed_total, want.runs);
        check_field("error_total", error_total, want.failures);
        check_field("lateness_total", lateness_total, want.lateness);
        check_field("duration_total", duration_total, want.duration);
        check_field("skipped_total", skipped_total, want.skips);
        outcomes_checked++;
      end
    end
  end

  // Offer one item after an optional gap; start stays high for a following beat
  task automatic send_job(input job_t job, input int gap, output outcome_t predicted);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = job.func;
    current_time = job.now;
    task_number = job.slot;
    start_time = job.t_start;
    finish_time = job.t_finish;
    job_failed = job.failed;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predicted = schedule_step(job);
    pending_outcomes.push_back(predicted);
    if (job.func == FUNC_SELECT) begin
      selects_sent++;
      if (predicted.found) selects_found++;
    end else begin
      completions_sent++;
    end
  endtask

  task automatic select_at(input bit [63:0] now);
    job_t     job;
    outcome_t res;
    job = '0;
    job.func = FUNC_SELECT;
    job.now = now;
    send_job(job, pick_gap(), res);
  endtask

  task automatic complete_slot(input int slot, input bit [63:0] t_start,
                               input bit [63:0] t_finish, input bit failed);
    job_t     job;
    outcome_t res;
    job = '0;
    job.func = FUNC_COMPLETE;
    job.slot = slot;
    job.t_start = t_start;
    job.t_finish = t_finish;
    job.failed = failed;
    send_job(job, pick_gap(), res);
  endtask

  // Hold off until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input int idx, input bit [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ACTIVE)
      model_active = value[2:0];
    else if (idx >= REG_INTV0 && idx < REG_INTV0 + INTV_REGS)
      model_intv[idx - REG_INTV0] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_empty_schedule();
    select_at(0);
    select_at(TIME_MAX);
  endtask

  // Active count above the slot count acts as all slots
  task automatic test_slot_limit();
    drain();
    write_register(REG_ACTIVE, '1);
    select_at(0);
    complete_slot(0, 0, 10, 1'b0);
    select_at(500);
  endtask

  task automatic test_interval_extremes();
    drain();
    write_register(REG_INTV0 + 1, 32'd0);
    write_register(REG_INTV0 + 2, 32'd1);
    write_register(REG_INTV0, '1);
    complete_slot(1, 3, 20, 1'b1);
    complete_slot(2, 2, 7, 1'b0);
    complete_slot(0, 5, 9, 1'b1);
  endtask

  // Completion outside the active range, early start and finish before start
  task automatic test_inactive_slot();
    drain();
    write_register(REG_ACTIVE, 32'h0000_FFFA);
    complete_slot(3, 100, 50, 1'b0);
    complete_slot(2, 0, 0, 1'b0);
    select_at(TIME_MAX);
  endtask

  task automatic test_spare_indexes();
    drain();
    for (int i = REG_SPARE_FIRST; i <= REG_LAST; i++) write_register(i, $urandom);
    select_at(30);
  endtask

  task automatic test_lateness_saturation();
    complete_slot(0, TIME_MAX, 0, 1'b1);
    complete_slot(0, TIME_MAX, 0, 1'b0);
  endtask

  // Slot 3 runs out of time: due time and skip count both saturate
  task automatic test_time_saturation();
    drain();
    write_register(REG_INTV0 + 3, 32'd1);
    write_register(REG_ACTIVE, SLOTS);
    complete_slot(3, 0, TIME_MAX, 1'b0);
    complete_slot(3, TIME_MAX, TIME_MAX, 1'b1);
    select_at(TIME_MAX);
    select_at(0);
  endtask

  task automatic test_random_schedule();
    outcome_t  res;
    job_t      job;
    bit [63:0] base, now, iv;
    int        sent, r;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      gaps_on = (p != 2);
      for (int i = 0; i < INTV_REGS; i++) write_register(REG_INTV0 + i, pick_interval());
      case ($urandom_range(0, 7))
        0: r = 0;
        1: r = $urandom;
        2: r = $urandom_range(5, 7);
        default: r = $urandom_range(1, 4);
      endcase
      write_register(REG_ACTIVE, (p == 0) ? SLOTS : r);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 2 &&
            (p == 0 || $urandom_range(0, 1) == 0))
          drain();
        r = $urandom_range(0, 99);
        job = '0;
        if (r < 8) begin
          // Noise: select at any time
          select_at(rand_time());
          sent++;
        end else if (r < 12) begin
          // Noise: completion with arbitrary times
          job.t_start = rand_time();
          complete_slot($urandom_range(0, SLOTS - 1), job.t_start,
                        ($urandom_range(0, 3) == 0) ? rand_time()
                          : add_clamped(job.t_start, $urandom_range(0, 100), TIME_MAX),
                        $urandom_range(0, 1));
          sent++;
        end else begin
          // Well-formed round: poll near the earliest due time, then finish that task
          base = earliest_due();
          if ($urandom_range(0, 5) == 0 && base > 50)
            now = base - $urandom_range(1, 50);
          else
            now = add_clamped(base, $urandom_range(0, 30), TIME_MAX);
          job.func = FUNC_SELECT;
          job.now = now;
          send_job(job, pick_gap(), res);
          sent++;
          if (res.found) begin
            iv = (model_intv[res.slot] == 0) ? 64'd1 : model_intv[res.slot];
            job.t_start = add_clamped(now, $urandom_range(0, 20), TIME_MAX);
            case ($urandom_range(0, 7))
              0: job.t_finish = (job.t_start > 5) ? job.t_start - 5 : 0;
              1, 2: job.t_finish = add_clamped(job.t_start,
                                               iv * $urandom_range(1, 4) + $urandom_range(0, 9),
                                               TIME_MAX);
              default: job.t_finish = add_clamped(job.t_start, $urandom_range(0, 40), TIME_MAX);
            endcase
            complete_slot(res.slot, job.t_start, job.t_finish, $urandom_range(0, 7) == 0);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    model_active = '0;
    for (int i = 0; i < SLOTS; i++) begin
      model_intv[i] = INTV_RESET;
      model_due[i] = 0;
      model_skip[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_schedule();
    test_slot_limit();
    test_interval_extremes();
    test_inactive_slot();
    test_spare_indexes();
    test_lateness_saturation();
    test_time_saturation();
    test_random_schedule();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_mismatch("results never returned", pending_outcomes.size(), 0);
    $display("covered %0d selects (%0d found a due slot), %0d completions (%0d caught up)",
             selects_sent, selects_found, completions_sent, catch_ups);
    $display("checked %0d results, %0d mismatches", outcomes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(12 * 2_000_000);
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("FAIL");
    $finish;
  end

endmodule

[periodic_task_due_scheduler_core.f]
design/ptds_pkg.sv
design/ptds_divider.sv
design/periodic_task_due_scheduler_core.sv
tb/testbench.sv
